// ----- hw/rtl/iaf_pkg.sv -----
package iaf_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned ModeWidth  = 3;
  localparam int unsigned CharWidth  = 7;
  localparam int unsigned CountWidth = 5;

  // Format modes
  localparam logic [ModeWidth-1:0] MODE_SDEC  = 3'd0;
  localparam logic [ModeWidth-1:0] MODE_UDEC  = 3'd1;
  localparam logic [ModeWidth-1:0] MODE_HEXLO = 3'd2;
  localparam logic [ModeWidth-1:0] MODE_HEXUP = 3'd3;
  localparam logic [ModeWidth-1:0] MODE_PTR   = 3'd4;

  localparam logic [CharWidth-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CharWidth-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CharWidth-1:0] CHAR_X     = 7'h78;
  localparam logic [CharWidth-1:0] CHAR_UPPER_A = 7'h41;
  localparam logic [CharWidth-1:0] CHAR_LOWER_A = 7'h61;

  // Digit counts per mode
  localparam logic [4:0] DEC_DIGITS = 5'd10;
  localparam logic [4:0] HEX_DIGITS = 5'd8;
  localparam logic [4:0] PTR_DIGITS = 5'd16;

  localparam int unsigned BcdWidth = 40;

  function automatic logic [CharWidth-1:0] digit_char(input logic [3:0] d,
                                                      input logic upper);
    logic [CharWidth-1:0] base;
    base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
    if (d < 4'd10) begin
      digit_char = CHAR_ZERO + {3'b000, d};
    end else begin
      digit_char = base + {3'b000, d - 4'd10};
    end
  endfunction

endpackage

// ----- hw/rtl/integer_to_ascii_formatter.sv -----
// Integer to ASCII formatter. Pulse start_i while busy_o is low to hand in a
// value and a mode; the block then drives one character per strobe_o cycle,
// most significant first, with emitted_count_o counting from 1 and last_o on
// the final beat. There is no back-pressure: each beat is on the ports for one
// cycle only, so the receiver must take it then. Decimal modes run the low 32
// bits through a bit-serial shift-and-add-3 converter, then drop leading zeros
// one digit per cycle, leave the skip, and emit the sign and the remaining
// digits. Skipped and printed digits share ten places. Hex modes print the low
// 32 bits as 8 digits and pointer mode all 64 bits as 16 digits after "0x",
// each dropping leading zeros the same way; every beat leaves through an
// output register. A zero value still prints one '0'. Modes 5 to 7 are taken
// and produce no beats and no busy_o. In the other modes busy_o is high from
// the cycle after acceptance until the last beat; it is already low during
// that beat, so the next item can be taken then.
module integer_to_ascii_formatter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [iaf_pkg::ValueWidth-1:0]   value_i,
  input  logic [iaf_pkg::ModeWidth-1:0]    mode_i,
  output logic                             strobe_o,
  output logic [iaf_pkg::CharWidth-1:0]    character_o,
  output logic [iaf_pkg::CountWidth-1:0]   emitted_count_o,
  output logic                             last_o
);
  import iaf_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;  // bit-serial binary to BCD
  localparam logic [2:0] ST_SKIP = 3'd2;  // drop leading zero digits
  localparam logic [2:0] ST_PFX  = 3'd3;  // sign or "0x"
  localparam logic [2:0] ST_DIG  = 3'd4;  // one digit per beat

  logic [2:0]            state_q, state_d;
  logic [ValueWidth-1:0] dig_q, dig_d;     // digits, most significant at top
  logic [31:0]           bin_q, bin_d;     // binary shifted out MSB first
  logic [4:0]            bitcnt_q, bitcnt_d;
  logic [4:0]            ndig_q, ndig_d;   // digits left in dig_q
  logic [1:0]            pfx_q, pfx_d;     // prefix characters left
  logic                  ptr_q, ptr_d;
  logic                  upper_q, upper_d;
  logic [CountWidth-1:0] cnt_q, cnt_d;

  logic                  strobe_q, strobe_d;
  logic [CharWidth-1:0]  char_q, char_d;
  logic [CountWidth-1:0] ecnt_q, ecnt_d;
  logic                  last_q, last_d;

  logic [31:0]           low;
  logic [31:0]           mag;
  logic [BcdWidth-1:0]   bcd_adj;
  logic [3:0]            top;

  assign low = value_i[31:0];
  assign mag = ((mode_i == MODE_SDEC) && low[31]) ? 32'(~low + 32'd1) : low;
  assign top = dig_q[ValueWidth-1 -: 4];

  // Add 3 to every BCD digit of 5 or more before the next shift
  always_comb begin
    for (int i = 0; i < BcdWidth / 4; i++) begin
      if (dig_q[ValueWidth-BcdWidth+4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = dig_q[ValueWidth-BcdWidth+4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = dig_q[ValueWidth-BcdWidth+4*i +: 4];
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    dig_d    = dig_q;
    bin_d    = bin_q;
    bitcnt_d = bitcnt_q;
    ndig_d   = ndig_q;
    pfx_d    = pfx_q;
    ptr_d    = ptr_q;
    upper_d  = upper_q;
    cnt_d    = cnt_q;
    strobe_d = 1'b0;
    char_d   = char_q;
    ecnt_d   = ecnt_q;
    last_d   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cnt_d    = '0;
          bitcnt_d = 5'd31;
          bin_d    = mag;
          ptr_d    = 1'b0;
          upper_d  = 1'b0;
          pfx_d    = 2'd0;
          priority if (mode_i == MODE_SDEC || mode_i == MODE_UDEC) begin
            dig_d   = '0;
            ndig_d  = DEC_DIGITS;
            pfx_d   = ((mode_i == MODE_SDEC) && low[31]) ? 2'd1 : 2'd0;
            state_d = ST_CONV;
          end else if (mode_i == MODE_HEXLO || mode_i == MODE_HEXUP) begin
            dig_d   = {low, 32'd0};
            ndig_d  = HEX_DIGITS;
            upper_d = (mode_i == MODE_HEXUP);
            state_d = ST_SKIP;
          end else if (mode_i == MODE_PTR) begin
            dig_d   = value_i;
            ndig_d  = PTR_DIGITS;
            ptr_d   = 1'b1;
            pfx_d   = 2'd2;
            state_d = ST_SKIP;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_CONV: begin
        dig_d = {bcd_adj[BcdWidth-2:0], bin_q[31], dig_q[ValueWidth-BcdWidth-1:0]};
        bin_d = {bin_q[30:0], 1'b0};
        bitcnt_d = bitcnt_q - 5'd1;
        if (bitcnt_q == 5'd0) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top == 4'd0 && ndig_q > 5'd1) begin
          dig_d  = {dig_q[ValueWidth-5:0], 4'd0};
          ndig_d = ndig_q - 5'd1;
        end else begin
          state_d = (pfx_q != 2'd0) ? ST_PFX : ST_DIG;
        end
      end
      ST_PFX: begin
        strobe_d = 1'b1;
        cnt_d    = cnt_q + 5'd1;
        ecnt_d   = cnt_q + 5'd1;
        if (ptr_q) begin
          char_d = (pfx_q == 2'd2) ? CHAR_ZERO : CHAR_X;
        end else begin
          char_d = CHAR_MINUS;
        end
        pfx_d = pfx_q - 2'd1;
        if (pfx_q == 2'd1) begin
          state_d = ST_DIG;
        end
      end
      ST_DIG: begin
        strobe_d = 1'b1;
        cnt_d    = cnt_q + 5'd1;
        ecnt_d   = cnt_q + 5'd1;
        char_d   = digit_char(top, upper_q);
        dig_d    = {dig_q[ValueWidth-5:0], 4'd0};
        ndig_d   = ndig_q - 5'd1;
        if (ndig_q == 5'd1) begin
          last_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
      cnt_q    <= '0;
      ecnt_q   <= '0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
      last_q   <= last_d;
      cnt_q    <= cnt_d;
      ecnt_q   <= ecnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q    <= dig_d;
    bin_q    <= bin_d;
    bitcnt_q <= bitcnt_d;
    ndig_q   <= ndig_d;
    pfx_q    <= pfx_d;
    ptr_q    <= ptr_d;
    upper_q  <= upper_d;
    char_q   <= char_d;
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign strobe_o        = strobe_q;
  assign character_o     = char_q;
  assign emitted_count_o = ecnt_q;
  assign last_o          = last_q;

  // A run's beats come on consecutive cycles, counting up by one
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |=> strobe_o && emitted_count_o == $past(emitted_count_o) + 5'd1)
    else $error("gap or miscount inside a character run");

  // The beat after the last one is never a beat
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |=> !strobe_o)
    else $error("beat right after last");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> emitted_count_o != 5'd0 && emitted_count_o <= 5'd18)
    else $error("emitted count out of range");

  // A valid mode makes the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && mode_i <= MODE_PTR |=> busy_o)
    else $error("valid item not taken up");

  // Beats only come while a run is in progress or on its last cycle
  a_strobe_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |-> busy_o)
    else $error("beat outside a run");

endmodule

// ----- sim/integer_to_ascii_formatter_test.sv -----
module integer_to_ascii_formatter_test;

  import iaf_pkg::*;

  localparam logic [ModeWidth-1:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [ModeWidth-1:0] MODE_UNUSED_LAST  = 3'd7;
  localparam int unsigned MaxChars      = 18;
  localparam int unsigned ReportLimit   = 10;
  // Worst item's block work plus a sender gap stays far below this limit.
  localparam int unsigned StallLimit    = 4000;
  localparam int unsigned DrainCycles   = 80;
  localparam int unsigned RandomPerPass = 50;

  typedef struct packed {
    logic [CharWidth-1:0]  ch;
    logic [CountWidth-1:0] count;
    logic                  last;
  } char_beat_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [ValueWidth-1:0] value_i;
  logic [ModeWidth-1:0]  mode_i;
  logic                  strobe_o;
  logic [CharWidth-1:0]  character_o;
  logic [CountWidth-1:0] emitted_count_o;
  logic                  last_o;

  char_beat_t  pending_chars[$];
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned sender_idle_pct;

  integer_to_ascii_formatter u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .value_i         (value_i),
    .mode_i          (mode_i),
    .strobe_o        (strobe_o),
    .character_o     (character_o),
    .emitted_count_o (emitted_count_o),
    .last_o          (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Expected characters of one item, pushed in emit order.
  task automatic format_to_chars(input logic [ValueWidth-1:0] value,
                                 input logic [ModeWidth-1:0] mode);
    string       lo_set;
    string       up_set;
    string       digit_set;
    logic [63:0] mag;
    logic [31:0] low;
    int unsigned base;
    byte         text[MaxChars];
    byte         rev[20];
    int          len;
    int          nd;
    char_beat_t  beat;
    lo_set = "0123456789abcdef";
    up_set = "0123456789ABCDEF";
    digit_set = lo_set;
    low = value[31:0];
    len = 0;
    nd = 0;
    base = 16;
    case (mode)
      MODE_SDEC: begin
        base = 10;
        if (low[31]) begin
          text[len] = "-";
          len++;
          low = ~low + 32'd1;
        end
        mag = {32'd0, low};
      end
      MODE_UDEC: begin
        base = 10;
        mag = {32'd0, low};
      end
      MODE_HEXLO: mag = {32'd0, low};
      MODE_HEXUP: begin
        mag = {32'd0, low};
        digit_set = up_set;
      end
      MODE_PTR: begin
        text[0] = "0";
        text[1] = "x";
        len = 2;
        mag = value;
      end
      default: return;  // unused modes emit nothing
    endcase
    do begin
      rev[nd] = digit_set[int'(mag % base)];
      mag = mag / base;
      nd++;
    end while (mag != 0);
    while (nd > 0) begin
      nd--;
      text[len] = rev[nd];
      len++;
    end
    for (int k = 0; k < len; k++) begin
      beat.ch    = text[k][CharWidth-1:0];
      beat.count = CountWidth'(k + 1);
      beat.last  = (k == len - 1);
      pending_chars.push_back(beat);
    end
  endtask

  // Hands one item to the block; caller sits at a falling edge.
  task automatic send_item(input logic [ValueWidth-1:0] value,
                           input logic [ModeWidth-1:0] mode);
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i = 1'b1;
    value_i = value;
    mode_i  = mode;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    format_to_chars(value, mode);
    @(negedge clk_i);
  endtask

  function automatic logic [ValueWidth-1:0] random_value();
    logic [ValueWidth-1:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return {raw[63:32], 32'h8000_0000};
      3: return {raw[63:32], 32'h7FFF_FFFF};
      default: return raw >> $urandom_range(63);
    endcase
  endfunction

  task automatic test_directed();
    // signed: zero, one, extremes, most negative, minus one, upper bits ignored
    send_item(64'd0, MODE_SDEC);
    send_item(64'd1, MODE_SDEC);
    send_item(64'h0000_0000_7FFF_FFFF, MODE_SDEC);
    send_item(64'h0000_0000_8000_0000, MODE_SDEC);
    send_item(64'h0000_0000_FFFF_FFFF, MODE_SDEC);
    send_item(64'hDEAD_BEEF_0000_0005, MODE_SDEC);
    // unsigned, including values past the signed range
    send_item(64'd0, MODE_UDEC);
    send_item(64'h0000_0000_8000_0000, MODE_UDEC);
    send_item(64'hFFFF_FFFF_FFFF_FFFF, MODE_UDEC);
    send_item(64'd1_000_000_000, MODE_UDEC);
    // hex, both cases
    send_item(64'd0, MODE_HEXLO);
    send_item(64'hFFFF_FFFF_FFFF_FFFF, MODE_HEXLO);
    send_item(64'h1234_5678_ABCD_EF01, MODE_HEXLO);
    send_item(64'd0, MODE_HEXUP);
    send_item(64'h0000_0000_FFFF_FFFF, MODE_HEXUP);
    send_item(64'h0000_0000_ABCD_EF09, MODE_HEXUP);
    // pointer: zero, small, longest run
    send_item(64'd0, MODE_PTR);
    send_item(64'd1, MODE_PTR);
    send_item(64'hFFFF_FFFF_FFFF_FFFF, MODE_PTR);
    send_item(64'h8000_0000_0000_0000, MODE_PTR);
    send_item(64'hFEDC_BA98_7654_3210, MODE_PTR);
    // unused modes give no beats
    for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++) begin
      send_item(64'hFFFF_FFFF_FFFF_FFFF, ModeWidth'(m));
    end
  endtask

  task automatic test_random_mix(input int unsigned idle_pct,
                                 input int unsigned n_items);
    int unsigned served;
    logic [ModeWidth-1:0] mode;
    served = 0;
    sender_idle_pct = idle_pct;
    while (served < n_items) begin
      if ($urandom_range(15) == 0) begin
        mode = ModeWidth'($urandom_range(MODE_UNUSED_LAST, MODE_UNUSED_FIRST));
      end else begin
        mode = ModeWidth'($urandom_range(MODE_PTR, MODE_SDEC));
        served++;
      end
      send_item(random_value(), mode);
    end
  endtask

  task automatic note_mismatch(input char_beat_t want, input logic have_want);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) begin
      if (have_want) begin
        $display("mismatch: exp char %h count %0d last %b, got char %h count %0d last %b",
                 want.ch, want.count, want.last, character_o, emitted_count_o, last_o);
      end else begin
        $display("unexpected beat: char %h count %0d last %b",
                 character_o, emitted_count_o, last_o);
      end
    end
  endtask

  always @(posedge clk_i) begin : check_beats
    char_beat_t want;
    if (rst_ni && strobe_o === 1'b1) begin
      if (pending_chars.size() == 0) begin
        want = '0;
        note_mismatch(want, 1'b0);
      end else begin
        want = pending_chars.pop_front();
        if (character_o !== want.ch || emitted_count_o !== want.count ||
            last_o !== want.last) begin
          note_mismatch(want, 1'b1);
        end
      end
    end
  end

  // Watchdog: cycles with neither an accepted item nor a beat.
  always @(posedge clk_i) begin
    if ((start_i && busy_o === 1'b0) || strobe_o === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("FAIL integer_to_ascii_formatter");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    value_i = '0;
    mode_i = '0;
    sender_idle_pct = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    sender_idle_pct = 21;
    test_directed();
    test_random_mix(21, RandomPerPass);
    test_random_mix(62, RandomPerPass);
    test_random_mix(0, RandomPerPass);
    start_i = 1'b0;

    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("PASS integer_to_ascii_formatter");
    end else begin
      $display("FAIL integer_to_ascii_formatter");
    end
    $finish;
  end

endmodule
